// ----- rtl/tkk_pkg.sv -----
// ----------------------------------------------------------------------------
// tkk_pkg: shared constants and types for the top-k keeper
// Sizes of the entry chain, register indexes, beat layouts and cell control.
// ----------------------------------------------------------------------------
`default_nettype none

package tkk_pkg;

    localparam int MAX_ENTRIES = 16;

    localparam int SCORE_W = 32;
    localparam int TAG_W   = 16;
    localparam int LIMIT_W = 5;
    localparam int OCC_W   = 5;
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 56;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_KEEP_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEDUP_ENABLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DUP_TOLERANCE = 2'd2;

    localparam logic [CNT_W-1:0]   LIMIT_RESET =
        CNT_W'((MAX_ENTRIES < 16) ? MAX_ENTRIES : 16);
    localparam logic [SCORE_W-1:0] TOL_RESET   = 32'd1;

    typedef struct packed {
        logic cmp_en;    // take compare flags against the candidate
        logic upd_en;    // insertion moves the chain this cycle
        logic occupied;  // cell holds a stored entry
        logic at_end;    // last cell touched by the insertion
        logic in_range;  // cell lies at or below the insertion end
    } cell_ctrl_t;

    // limit write: 0 becomes 1, above the chain length becomes the chain length
    function automatic logic [CNT_W-1:0] clamp_limit(input logic [LIMIT_W-1:0] v);
        logic [CMP_W-1:0] w;
        logic [CMP_W-1:0] r;
        w = CMP_W'(v);
        r = w;
        if (w == '0) begin
            r = CMP_W'(1);
        end else if (w > CMP_W'(MAX_ENTRIES)) begin
            r = CMP_W'(MAX_ENTRIES);
        end
        return CNT_W'(r);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/top_k_keeper_with_dedup.sv -----
// ----------------------------------------------------------------------------
// top_k_keeper_with_dedup: keeps the lowest-scored entries, sorted, with tags
//
//   channel   dir  beat contents
//   s_*       in   score_value, entry_tag
//   m_*       out  accepted, evicted_valid, evicted_tag, evicted_score,
//                  occupancy
//   cfg_*     in   register index and write data
//
// An item passes through accept, compare in every cell of the chain, then
// the chain update with the result loaded into the output register.
// The update waits while the output register still holds an untaken beat.
// Reset empties the store at once; entries are not cleared.
// Config writes are taken in any cycle; the limit moves only while the store is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_keeper_with_dedup
    import tkk_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,    // score_value, entry_tag
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata,    // accepted, evicted_valid,
                                                   // evicted_tag, evicted_score,
                                                   // occupancy, zero pad
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   limit_reg;
    logic               dedup_reg;
    logic [SCORE_W-1:0] tol_reg;

    logic [SCORE_W-1:0] cand_score_reg;
    logic [TAG_W-1:0]   cand_tag_reg;

    logic               m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic [SCORE_W-1:0] cell_score [MAX_ENTRIES];
    logic [TAG_W-1:0]   cell_tag   [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] cell_gt;
    logic [MAX_ENTRIES-1:0] cell_near;

    logic             s_fire;
    logic             upd_go;
    logic             reject;
    logic             full;
    logic             self_evict;
    logic             chain_upd;
    logic [CNT_W-1:0] cnt_eff;
    logic [IDX_W-1:0] last_idx;
    logic             ev_valid;
    logic [TAG_W-1:0] ev_tag;
    logic [SCORE_W-1:0] ev_score;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign upd_go     = (state_reg == ST_UPD) && (!m_valid_reg || m_tready);
    assign reject     = dedup_reg && (|cell_near);
    assign full       = count_reg >= limit_reg;
    // gt flags form a thermometer, so no flag set means not below the top entry
    assign self_evict = full && !(|cell_gt);
    assign chain_upd  = upd_go && !reject && !self_evict;
    assign cnt_eff    = full ? (count_reg - CNT_W'(1)) : count_reg;
    assign last_idx   = IDX_W'(count_reg - CNT_W'(1));

    always_comb begin
        ev_valid = 1'b0;
        ev_tag   = '0;
        ev_score = '0;
        if (!reject && full) begin
            ev_valid = 1'b1;
            if (self_evict) begin
                ev_tag   = cand_tag_reg;
                ev_score = cand_score_reg;
            end else begin
                ev_tag   = cell_tag[last_idx];
                ev_score = cell_score[last_idx];
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (upd_go && !reject && !full) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb begin
        m_data_next = {1'b0, OCC_W'(count_next), ev_score, ev_tag, ev_valid, !reject};
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (upd_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            limit_reg   <= LIMIT_RESET;
            dedup_reg   <= 1'b0;
            tol_reg     <= TOL_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (upd_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_KEEP_LIMIT: begin
                        if (count_reg == '0) begin
                            limit_reg <= clamp_limit(cfg_data[LIMIT_W-1:0]);
                        end
                    end
                    REG_DEDUP_ENABLE: begin
                        dedup_reg <= cfg_data[0];
                    end
                    REG_DUP_TOLERANCE: begin
                        tol_reg <= cfg_data[SCORE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cand_score_reg <= s_tdata[SCORE_W-1:0];
            cand_tag_reg   <= s_tdata[SCORE_W+TAG_W-1:SCORE_W];
        end
        if (upd_go) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        cell_ctrl_t         ctrl;
        logic [SCORE_W-1:0] prev_score;
        logic [TAG_W-1:0]   prev_tag;
        logic               prev_gt;

        assign ctrl.cmp_en   = (state_reg == ST_CMP);
        assign ctrl.upd_en   = chain_upd;
        assign ctrl.occupied = CNT_W'(g) < count_reg;
        assign ctrl.at_end   = CNT_W'(g) == cnt_eff;
        assign ctrl.in_range = CNT_W'(g) <= cnt_eff;

        if (g == 0) begin : g_first
            assign prev_score = '0;
            assign prev_tag   = '0;
            assign prev_gt    = 1'b0;
        end else begin : g_next
            assign prev_score = cell_score[g-1];
            assign prev_tag   = cell_tag[g-1];
            assign prev_gt    = cell_gt[g-1];
        end

        tkk_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .cand_score (cand_score_reg),
            .cand_tag   (cand_tag_reg),
            .tolerance  (tol_reg),
            .prev_score (prev_score),
            .prev_tag   (prev_tag),
            .prev_gt    (prev_gt),
            .score      (cell_score[g]),
            .tag        (cell_tag[g]),
            .gt         (cell_gt[g]),
            .near       (cell_near[g])
        );
    end

endmodule

`default_nettype wire

// ----- rtl/tkk_cell.sv -----
// ----------------------------------------------------------------------------
// tkk_cell: one slot of the sorted entry chain
// Holds a score and tag, compares them with the candidate, and on insertion
// takes the neighbor's entry or the candidate.
// ----------------------------------------------------------------------------
`default_nettype none

module tkk_cell
    import tkk_pkg::*;
(
    input  wire logic               aclk,
    input  wire cell_ctrl_t         ctrl,
    input  wire logic [SCORE_W-1:0] cand_score,
    input  wire logic [TAG_W-1:0]   cand_tag,
    input  wire logic [SCORE_W-1:0] tolerance,
    input  wire logic [SCORE_W-1:0] prev_score,
    input  wire logic [TAG_W-1:0]   prev_tag,
    input  wire logic               prev_gt,
    output logic [SCORE_W-1:0]      score,
    output logic [TAG_W-1:0]        tag,
    output logic                    gt,
    output logic                    near
);

    logic [SCORE_W-1:0] score_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic               gt_reg;
    logic               near_reg;
    logic               above;
    logic [SCORE_W-1:0] diff;

    assign above = score_reg > cand_score;
    assign diff  = above ? (score_reg - cand_score) : (cand_score - score_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.cmp_en) begin
            gt_reg   <= ctrl.occupied && above;
            near_reg <= ctrl.occupied && (diff <= tolerance);
        end
        if (ctrl.upd_en && ctrl.in_range) begin
            // entries above the insertion point move up one slot
            if (prev_gt) begin
                score_reg <= prev_score;
                tag_reg   <= prev_tag;
            end else if (gt_reg || ctrl.at_end) begin
                score_reg <= cand_score;
                tag_reg   <= cand_tag;
            end
        end
    end

    assign score = score_reg;
    assign tag   = tag_reg;
    assign gt    = gt_reg;
    assign near  = near_reg;

endmodule

`default_nettype wire

// ----- rtl/tkk_checker.sv -----
// ----------------------------------------------------------------------------
// tkk_checker: port-level checks for the top-k keeper
// Watches the stream and result beats and flags inconsistent results.
// ----------------------------------------------------------------------------
`default_nettype none

module tkk_checker
    import tkk_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_DATA_W-1:0]   m_tdata
);

    // one item at a time in the chain
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in flight");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    a_evict_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[1] && !m_tdata[0]))
        else $error("eviction reported on a rejected item");

    a_no_evict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[1] |-> m_tdata[49:2] == '0)
        else $error("evicted fields set without eviction");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[54:50] <= OCC_W'(MAX_ENTRIES))
        else $error("occupancy above chain length");

endmodule

bind top_k_keeper_with_dedup tkk_checker u_tkk_checker (.*);

`default_nettype wire

// ----- dv/tkk_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// tkk_tb_pkg: scoreboard for the top-k keeper testbench
// Mirrors the sorted store and the register state. Each accepted score beat
// yields one expected result beat, which is checked field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package tkk_tb_pkg;

    import tkk_pkg::*;

    // bit positions in the result beat
    localparam int ACC_BIT   = 0;
    localparam int EVV_BIT   = 1;
    localparam int ETAG_LO   = 2;
    localparam int ESCORE_LO = ETAG_LO + TAG_W;
    localparam int OCC_LO    = ESCORE_LO + SCORE_W;

    typedef struct packed {
        logic               accepted;
        logic               evicted_valid;
        logic [TAG_W-1:0]   evicted_tag;
        logic [SCORE_W-1:0] evicted_score;
        logic [OCC_W-1:0]   occupancy;
    } keep_result_t;

    class keep_scoreboard;
        logic [SCORE_W-1:0] scores [MAX_ENTRIES];
        logic [TAG_W-1:0]   tags [MAX_ENTRIES];
        int unsigned        fill;
        int unsigned        limit;
        bit                 dedup_on;
        logic [SCORE_W-1:0] tolerance;
        keep_result_t       awaited [$];
        int unsigned        errors;

        function new();
            fill      = 0;
            limit     = 32'(LIMIT_RESET);
            dedup_on  = 1'b0;
            tolerance = TOL_RESET;
            errors    = 0;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            int unsigned v;
            case (idx)
                REG_KEEP_LIMIT: begin
                    v = 32'(data[LIMIT_W-1:0]);
                    // the limit only moves while the store is empty
                    if (fill == 0) begin
                        if (v == 0) begin
                            v = 1;
                        end else if (v > MAX_ENTRIES) begin
                            v = MAX_ENTRIES;
                        end
                        limit = v;
                    end
                end
                REG_DEDUP_ENABLE: begin
                    dedup_on = data[0];
                end
                REG_DUP_TOLERANCE: begin
                    tolerance = data;
                end
                default: begin
                end
            endcase
        endfunction

        function bit near_stored(logic [SCORE_W-1:0] sc);
            logic [SCORE_W-1:0] gap;
            for (int unsigned i = 0; i < fill; i++) begin
                gap = (scores[i] > sc) ? scores[i] - sc : sc - scores[i];
                if (gap <= tolerance) begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // equal scores keep arrival order: the new entry goes after them
        function void insert_entry(logic [SCORE_W-1:0] sc, logic [TAG_W-1:0] tg);
            int unsigned pos;
            pos = 0;
            while (pos < fill && scores[pos] <= sc) begin
                pos++;
            end
            for (int unsigned i = fill; i > pos; i--) begin
                scores[i] = scores[i-1];
                tags[i]   = tags[i-1];
            end
            scores[pos] = sc;
            tags[pos]   = tg;
            fill++;
        endfunction

        function void note_input(logic [SCORE_W-1:0] sc, logic [TAG_W-1:0] tg);
            keep_result_t r;
            r = '0;
            if (!(dedup_on && near_stored(sc))) begin
                r.accepted = 1'b1;
                if (fill >= limit) begin
                    r.evicted_valid = 1'b1;
                    if (sc >= scores[fill-1]) begin
                        // new entry is not below the largest stored score, it leaves at once
                        r.evicted_tag   = tg;
                        r.evicted_score = sc;
                    end else begin
                        fill--;
                        r.evicted_tag   = tags[fill];
                        r.evicted_score = scores[fill];
                        insert_entry(sc, tg);
                    end
                end else begin
                    insert_entry(sc, tg);
                end
            end
            r.occupancy = OCC_W'(fill);
            awaited.push_back(r);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
            errors++;
        endtask

        task check_result(logic [M_DATA_W-1:0] beat);
            keep_result_t want;
            if (awaited.size() == 0) begin
                report("result beat with nothing outstanding", 64'(beat), 64'd0);
                return;
            end
            want = awaited.pop_front();
            if (beat[ACC_BIT] !== want.accepted) begin
                report("accepted", 64'(beat[ACC_BIT]), 64'(want.accepted));
            end
            if (beat[EVV_BIT] !== want.evicted_valid) begin
                report("evicted_valid", 64'(beat[EVV_BIT]), 64'(want.evicted_valid));
            end
            if (beat[ETAG_LO +: TAG_W] !== want.evicted_tag) begin
                report("evicted_tag", 64'(beat[ETAG_LO +: TAG_W]), 64'(want.evicted_tag));
            end
            if (beat[ESCORE_LO +: SCORE_W] !== want.evicted_score) begin
                report("evicted_score", 64'(beat[ESCORE_LO +: SCORE_W]),
                       64'(want.evicted_score));
            end
            if (beat[OCC_LO +: OCC_W] !== want.occupancy) begin
                report("occupancy", 64'(beat[OCC_LO +: OCC_W]), 64'(want.occupancy));
            end
        endtask
    endclass

endpackage

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for top_k_keeper_with_dedup
// Directed beats cover score extremes, ties, self-eviction, the duplicate
// window at both ends and limit clamping, then random phases under varied
// register settings with random sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    import tkk_pkg::*;
    import tkk_tb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 238;
    localparam int STALL_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 8;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int unsigned    src_idle_pct = 0;
    int unsigned    sink_stall_pct = 0;
    int unsigned    quiet_cycles = 0;
    keep_scoreboard sb;

    top_k_keeper_with_dedup dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("top_k_keeper_with_dedup: mismatch");
            $finish;
        end
    end

    // leaves tvalid high so back-to-back beats need no extra edge
    task automatic send_item(input logic [SCORE_W-1:0] sc, input logic [TAG_W-1:0] tg);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tg, sc};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(sc, tg);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
        @(posedge aclk);
    endtask

    // mostly scores that land inside the kept range, so the chain keeps moving
    function automatic logic [SCORE_W-1:0] pick_score();
        int unsigned        r;
        logic [SCORE_W-1:0] top;
        r = $urandom_range(99);
        if (sb.fill == 0 || r < 20) begin
            return $urandom();
        end
        top = sb.scores[sb.fill-1];
        if (r < 45) begin
            return $urandom_range(top);
        end
        if (r < 65) begin
            return sb.scores[$urandom_range(sb.fill-1)] + $urandom_range(4) - 2;
        end
        if (r < 80) begin
            return top;
        end
        if (r < 88) begin
            return ($urandom_range(1) != 0) ? '1 : '0;
        end
        return $urandom_range(63);
    endfunction

    initial begin
        int unsigned        lim_pick;
        logic [SCORE_W-1:0] tol;
        bit                 dedup_bit;

        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // limit clamping, ignored index, then the limit used for the whole run
        lim_pick = $urandom_range(7);
        write_reg(REG_KEEP_LIMIT, 32'd0);
        write_reg(REG_KEEP_LIMIT, 32'd31);
        write_reg(REG_KEEP_LIMIT, 32'd17);
        write_reg(REG_UNUSED, $urandom());
        write_reg(REG_KEEP_LIMIT, (lim_pick == 0) ? 32'd1 :
                                  (lim_pick < 3) ? 32'd16 : $urandom_range(15, 2));
        cfg_valid <= 1'b0;

        send_item('1, '1);
        send_item('0, '0);
        send_item(32'h0001_0000, 16'd1);
        send_item(32'h0001_0000, 16'd2);
        for (int i = 0; i < 6 && sb.fill < sb.limit; i++) begin
            send_item($urandom_range(32'h0002_0000, 32'h10), TAG_W'($urandom()));
        end
        // tie with the largest (leaves itself when full), then one just below it
        send_item(sb.scores[sb.fill-1], 16'h00A5);
        send_item(sb.scores[sb.fill-1] - 1, 16'h005A);

        wait_drained();
        write_reg(REG_DEDUP_ENABLE, 32'd1);
        write_reg(REG_DUP_TOLERANCE, 32'd0);
        cfg_valid <= 1'b0;
        send_item(sb.scores[0], 16'h1111);
        send_item(sb.scores[0] + 1, 16'h2222);

        // window covering everything, clipped at both ends
        wait_drained();
        write_reg(REG_DUP_TOLERANCE, '1);
        cfg_valid <= 1'b0;
        send_item('0, 16'h3333);
        send_item('1, 16'h4444);

        wait_drained();
        write_reg(REG_DUP_TOLERANCE, 32'd1);
        write_reg(REG_KEEP_LIMIT, 32'd3);
        cfg_valid <= 1'b0;
        send_item(32'hFFFF_FFFE, 16'h5555);
        send_item(32'd1, 16'h6666);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin dedup_bit = 1'b0; tol = 32'd1; end
                1: begin dedup_bit = 1'b1; tol = 32'd0; end
                2: begin dedup_bit = 1'b1; tol = $urandom_range(16, 1); end
                3: begin dedup_bit = 1'b0; tol = $urandom(); end
                4: begin dedup_bit = 1'b1; tol = $urandom_range(32'h0002_0000); end
                5: begin dedup_bit = 1'b1; tol = 32'd1; end
                6: begin dedup_bit = 1'b0; tol = '1; end
                default: begin dedup_bit = 1'b1; tol = $urandom_range(3); end
            endcase
            wait_drained();
            write_reg(REG_KEEP_LIMIT, $urandom_range(31));
            write_reg(REG_DEDUP_ENABLE, ($urandom() & ~32'd1) | 32'(dedup_bit));
            write_reg(REG_DUP_TOLERANCE, tol);
            cfg_valid <= 1'b0;
            src_idle_pct   = (p % 4 == 1) ? 47 : (p % 4 == 3) ? 26 : 0;
            sink_stall_pct = (p % 4 == 2) ? 47 : (p % 4 == 3) ? 26 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold off until the pipeline is empty, then restart
                if (n == PHASE_ITEMS / 2 && p % 2 == 1) begin
                    wait_drained();
                end
                send_item(pick_score(), TAG_W'($urandom()));
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("top_k_keeper_with_dedup: match");
        end else begin
            $display("top_k_keeper_with_dedup: mismatch");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/tkk_pkg.sv
rtl/tkk_cell.sv
rtl/top_k_keeper_with_dedup.sv
rtl/tkk_checker.sv
dv/tkk_tb_pkg.sv
dv/tb_top.sv
